@@ hw/rtl/cqpc_pkg.sv @@
// Types, codes and constants shared by the circular queue palindrome checker.
`default_nettype none

package cqpc_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OPC_W = 2;
	localparam int unsigned STAT_W = 2;
	localparam int unsigned COUNT_OUT_W = 8;

	// Command codes.
	localparam logic [OPC_W-1:0] OP_ENQ = 2'd0;
	localparam logic [OPC_W-1:0] OP_DEQ = 2'd1;
	localparam logic [OPC_W-1:0] OP_CHK = 2'd2;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// Head value reported for an empty queue.
	localparam logic signed [WORD_W-1:0] EMPTY_HEAD = -32'sd1;

	typedef struct packed {
		logic [OPC_W-1:0] opcode;
		logic signed [WORD_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic signed [WORD_W-1:0] head_value;
		logic is_empty;
		logic is_full;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic is_palindrome;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic exec;
		logic rd_pair;
		logic cmp_step;
		logic rd_head;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic chk_go;
		logic mismatch;
		logic pair_last;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/cqpc_chan_if.sv @@
// Valid/ready channel interface carrying one payload of a chosen type.
`default_nettype none

interface cqpc_chan_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cqpc_dp.sv @@
// Datapath: entry memory, queue pointers, pair comparison and result register.
`default_nettype none

module cqpc_dp
	import cqpc_pkg::*;
#(
	parameter int unsigned DEPTH = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire in_item_t in_data,
	input wire cmd_t cmd,
	output stat_t st,
	output logic res_valid,
	input wire logic res_ready,
	output out_item_t res_data
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WORD_W-1:0] mem [DEPTH];

	logic [OPC_W-1:0] op_q;
	logic [WORD_W-1:0] value_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] lo_q;
	logic [IDX_W-1:0] hi_q;
	logic [CNT_W-1:0] pairs_q;
	logic [STAT_W-1:0] status_q;
	logic pal_q;
	logic [WORD_W-1:0] rd_a_q;
	logic [WORD_W-1:0] rd_b_q;
	logic res_valid_q;
	out_item_t res_q;

	logic is_full;
	logic is_empty;
	logic [CNT_W-1:0] half_cnt;
	logic [IDX_W-1:0] rd_a_addr;
	logic mem_we;
	logic [CNT_W+COUNT_OUT_W-1:0] cnt_ext;

	assign is_full = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);
	assign half_cnt = count_q >> 1;
	assign mem_we = cmd.exec && (op_q == OP_ENQ) && !is_full;
	assign rd_a_addr = cmd.rd_head ? head_q : lo_q;
	assign cnt_ext = (CNT_W+COUNT_OUT_W)'(count_q);

	assign st.chk_go = (op_q == OP_CHK) && (half_cnt != '0);
	assign st.mismatch = (rd_a_q != rd_b_q);
	assign st.pair_last = (pairs_q == CNT_W'(1));
	assign st.out_free = !res_valid_q || res_ready;

	assign res_valid = res_valid_q;
	assign res_data = res_q;

	// Entry memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_pair || cmd.rd_head) begin
			rd_a_q <= mem[rd_a_addr];
		end
		if (cmd.rd_pair) begin
			rd_b_q <= mem[hi_q];
		end
	end

	// Captured command and pair-walk working registers.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q <= in_data.opcode;
			value_q <= in_data.value;
		end
		if (cmd.exec) begin
			lo_q <= head_q;
			hi_q <= (tail_q == '0) ? LAST_IDX : tail_q - 1'b1;
			pairs_q <= half_cnt;
			pal_q <= (op_q == OP_CHK);
			if (op_q == OP_ENQ && is_full) begin
				status_q <= ST_FULL;
			end else if (op_q == OP_DEQ && is_empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_OK;
			end
		end else if (cmd.cmp_step) begin
			if (st.mismatch) begin
				pal_q <= 1'b0;
			end else begin
				lo_q <= (lo_q == LAST_IDX) ? '0 : lo_q + 1'b1;
				hi_q <= (hi_q == '0) ? LAST_IDX : hi_q - 1'b1;
				pairs_q <= pairs_q - 1'b1;
			end
		end
		if (cmd.load_out) begin
			res_q.status <= status_q;
			res_q.head_value <= is_empty ? EMPTY_HEAD : $signed(rd_a_q);
			res_q.is_empty <= is_empty;
			res_q.is_full <= is_full;
			res_q.entry_count <= cnt_ext[COUNT_OUT_W-1:0];
			res_q.is_palindrome <= pal_q;
		end
	end

	// Queue pointers and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else if (cmd.exec) begin
			if (op_q == OP_ENQ && !is_full) begin
				tail_q <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (op_q == OP_DEQ && !is_empty) begin
				head_q <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("occupancy exceeds queue depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		is_empty |-> head_q == tail_q)
		else $error("empty queue with head and tail apart");

	a_partial_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		!is_empty && !is_full |-> head_q != tail_q)
		else $error("partly filled queue with head equal to tail");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !res_valid_q || res_ready)
		else $error("result register overwritten before its transaction");

	a_step_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp_step |-> pairs_q != '0)
		else $error("pair compare with no pairs left");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/cqpc_ctrl.sv @@
// Controller: sequences capture, update, pair compares and result loading.
`default_nettype none

module cqpc_ctrl
	import cqpc_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire stat_t st,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_EXEC = 6'b000010,
		S_CHK_RD = 6'b000100,
		S_CHK_CMP = 6'b001000,
		S_HEAD_RD = 6'b010000,
		S_LOAD = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d = st.chk_go ? S_CHK_RD : S_HEAD_RD;
			end
			S_CHK_RD: begin
				cmd.rd_pair = 1'b1;
				state_d = S_CHK_CMP;
			end
			S_CHK_CMP: begin
				cmd.cmp_step = 1'b1;
				state_d = (st.mismatch || st.pair_last) ? S_HEAD_RD : S_CHK_RD;
			end
			S_HEAD_RD: begin
				cmd.rd_head = 1'b1;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				// Hold the result until the previous one has left the register.
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == S_EXEC)
		else $error("accepted transaction not followed by execution");

	a_cmp_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp_step |-> $past(cmd.rd_pair))
		else $error("pair compare without a preceding read");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/circular_queue_palindrome_check.sv @@
// Top level of the circular queue with enqueue, dequeue and palindrome check.
//
//   channel  modport  payload     meaning
//   cmd      sink     in_item_t   one command: opcode and value
//   res      source   out_item_t  one result per command: status, head and flags
//
// An enqueue or dequeue passes from acceptance to a loaded result through capture, update,
// head read from the entry memory and result load. A check adds a pair read and a compare
// for each compared pair (at most DEPTH/2 pairs), up to the first mismatch. A new command
// is taken once the previous one has been loaded into the result register, even while
// that result still waits. The result load waits while the previous result has not been
// taken. Reset clears the pointers and the count at once; the memory needs no clearing.
`default_nettype none

module circular_queue_palindrome_check
	import cqpc_pkg::*;
#(
	parameter int unsigned DEPTH = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	cqpc_chan_if.sink cmd,
	cqpc_chan_if.source res
);

	cmd_t dp_cmd;
	stat_t dp_st;
	logic in_ready;
	logic res_valid;
	out_item_t res_data;
	in_item_t in_data;

	assign cmd.ready = in_ready;
	assign in_data = cmd.data;
	assign res.valid = res_valid;
	assign res.data = res_data;

	cqpc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(cmd.valid),
		.in_ready(in_ready),
		.st(dp_st),
		.cmd(dp_cmd)
	);

	cqpc_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_data(in_data),
		.cmd(dp_cmd),
		.st(dp_st),
		.res_valid(res_valid),
		.res_ready(res.ready),
		.res_data(res_data)
	);

endmodule

`default_nettype wire

@@ tb/sv/cqpc_result_checker.sv @@
// Checker that predicts the result of every accepted command and compares each result transaction.
`default_nettype none

module cqpc_result_checker
	import cqpc_pkg::*;
#(
	parameter int unsigned DEPTH = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire in_item_t cmd_data,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire out_item_t res_data,
	input wire logic end_of_test,
	output int unsigned fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [WORD_W-1:0] slot_word [DEPTH];
	int unsigned head_slot = 0;
	int unsigned tail_slot = 0;
	int unsigned held = 0;
	out_item_t status_due [$];
	bit leftovers_done = 1'b0;

	task automatic report_mismatch(input string what);
		$display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	// Applies one command to the shadow queue and returns the result it should produce.
	function automatic out_item_t step_queue(input in_item_t c);
		out_item_t r;
		int unsigned i;
		r = '0;
		r.status = ST_OK;
		case (c.opcode)
			OP_ENQ: begin
				if (held == DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot_word[tail_slot] = c.value;
					tail_slot = (tail_slot + 1) % DEPTH;
					held++;
				end
			end
			OP_DEQ: begin
				if (held == 0) begin
					r.status = ST_EMPTY;
				end else begin
					head_slot = (head_slot + 1) % DEPTH;
					held--;
				end
			end
			OP_CHK: begin
				// Pairs are taken relative to the head, so a wrapped queue is handled too.
				r.is_palindrome = 1'b1;
				for (i = 0; i < held / 2; i++) begin
					if (slot_word[(head_slot + i) % DEPTH] !=
							slot_word[(head_slot + held - 1 - i) % DEPTH]) begin
						r.is_palindrome = 1'b0;
					end
				end
			end
			default: begin
			end
		endcase
		r.head_value = (held == 0) ? EMPTY_HEAD : slot_word[head_slot];
		r.is_empty = (held == 0);
		r.is_full = (held == DEPTH);
		r.entry_count = COUNT_OUT_W'(held);
		return r;
	endfunction

	task automatic check_result(input out_item_t got, input out_item_t want);
		if (got.status !== want.status) begin
			report_mismatch($sformatf("status: got %0d, expected %0d", got.status, want.status));
		end
		if (got.head_value !== want.head_value) begin
			report_mismatch($sformatf("head_value: got %h, expected %h",
				got.head_value, want.head_value));
		end
		if (got.is_empty !== want.is_empty) begin
			report_mismatch($sformatf("is_empty: got %b, expected %b",
				got.is_empty, want.is_empty));
		end
		if (got.is_full !== want.is_full) begin
			report_mismatch($sformatf("is_full: got %b, expected %b", got.is_full, want.is_full));
		end
		if (got.entry_count !== want.entry_count) begin
			report_mismatch($sformatf("entry_count: got %0d, expected %0d",
				got.entry_count, want.entry_count));
		end
		if (got.is_palindrome !== want.is_palindrome) begin
			report_mismatch($sformatf("is_palindrome: got %b, expected %b",
				got.is_palindrome, want.is_palindrome));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot = 0;
			tail_slot = 0;
			held = 0;
			status_due.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (status_due.size() == 0) begin
					report_mismatch("result transaction with no command outstanding");
				end else begin
					check_result(res_data, status_due.pop_front());
				end
			end
			if (cmd_valid && cmd_ready) begin
				status_due.push_back(step_queue(cmd_data));
			end
			if (end_of_test && !leftovers_done) begin
				leftovers_done = 1'b1;
				if (status_due.size() != 0) begin
					report_mismatch($sformatf("%0d results never arrived", status_due.size()));
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ tb/sv/tb_circular_queue_palindrome_check.sv @@
// Testbench top: clock, reset, command stimulus, result back-pressure, watchdog and verdict.
`default_nettype none

module tb_circular_queue_palindrome_check;
	import cqpc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned DEPTH = 128;
	localparam int unsigned ITEM_TARGET = 1150;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic end_of_test = 1'b0;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;
	int unsigned cmds_sent = 0;
	int unsigned results_seen = 0;
	int unsigned idle_cycles = 0;
	int unsigned occupancy = 0;
	int unsigned fail_count;

	cqpc_chan_if #(.T(in_item_t)) cmd_ch ();
	cqpc_chan_if #(.T(out_item_t)) res_ch ();

	circular_queue_palindrome_check #(
		.DEPTH(DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.res(res_ch)
	);

	cqpc_result_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_ch.valid),
		.cmd_ready(cmd_ch.ready),
		.cmd_data(cmd_ch.data),
		.res_valid(res_ch.valid),
		.res_ready(res_ch.ready),
		.res_data(res_ch.data),
		.end_of_test(end_of_test),
		.fail_count(fail_count)
	);

	always #1 clk = ~clk;

	// Mostly extremes and a small pool of values, so that mirrored pairs also match by chance.
	function automatic logic [WORD_W-1:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return '0;
			3: return '1;
			4, 5: return WORD_W'($urandom_range(0, 3));
			default: return $urandom();
		endcase
	endfunction

	task automatic send_cmd(input logic [OPC_W-1:0] op, input logic [WORD_W-1:0] word);
		int unsigned gap;
		gap = tx_burst ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= in_item_t'{opcode: op, value: word};
		do @(posedge clk); while (!cmd_ch.ready);
		cmds_sent++;
		if (op == OP_ENQ && occupancy < DEPTH) begin
			occupancy++;
		end else if (op == OP_DEQ && occupancy > 0) begin
			occupancy--;
		end
	endtask

	// The sender goes idle first, so that the last command is not taken a second time.
	task automatic wait_all_results();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (results_seen != cmds_sent) @(posedge clk);
	endtask

	task automatic drain_queue();
		while (occupancy > 0) send_cmd(OP_DEQ, rand_word());
	endtask

	// Fills the queue with a symmetric sequence, optionally with one bit flipped, then checks it.
	task automatic load_mirror(input int unsigned len, input bit flaw);
		logic [WORD_W-1:0] words [DEPTH];
		int unsigned k;
		for (k = 0; k < (len + 1) / 2; k++) begin
			words[k] = rand_word();
			words[len - 1 - k] = words[k];
		end
		if (flaw && len > 1) begin
			k = $urandom_range(0, len - 1);
			words[k] = words[k] ^ (32'd1 << $urandom_range(0, 31));
		end
		for (k = 0; k < len; k++) send_cmd(OP_ENQ, words[k]);
		send_cmd(OP_CHK, rand_word());
	endtask

	initial begin
		int unsigned stall;
		res_ch.ready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = rx_burst ? 0 : $urandom_range(0, 19);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results_seen <= 0;
			idle_cycles <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				results_seen <= results_seen + 1;
			end
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("[circular_queue_palindrome_check] ERROR");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		int unsigned kind;
		int unsigned n;
		bit full_seen;
		full_seen = 1'b0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty queue, single entries, odd and even lengths, and the word extremes.
		send_cmd(OP_DEQ, rand_word());
		send_cmd(OP_CHK, rand_word());
		send_cmd(OP_ENQ, 32'h8000_0000);
		send_cmd(OP_CHK, rand_word());
		send_cmd(OP_ENQ, 32'h7fff_ffff);
		send_cmd(OP_CHK, rand_word());
		send_cmd(OP_ENQ, 32'h8000_0000);
		send_cmd(OP_CHK, rand_word());
		send_cmd(OP_ENQ, 32'h5555_5555);
		send_cmd(OP_ENQ, 32'haaaa_aaaa);
		send_cmd(OP_CHK, rand_word());
		send_cmd(OP_DEQ, rand_word());
		send_cmd(OP_CHK, rand_word());
		send_cmd(OP_DEQ, rand_word());
		send_cmd(OP_DEQ, rand_word());
		send_cmd(OP_DEQ, rand_word());
		send_cmd(OP_DEQ, rand_word());
		send_cmd(OP_CHK, rand_word());
		send_cmd(OP_ENQ, '1);
		send_cmd(OP_ENQ, '0);
		send_cmd(OP_ENQ, '1);
		send_cmd(OP_CHK, rand_word());
		drain_queue();
		wait_all_results();

		while (cmds_sent < ITEM_TARGET) begin
			kind = $urandom_range(0, 19);
			tx_burst = ($urandom_range(0, 3) == 0);
			rx_burst = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0) begin
				wait_all_results();
			end
			if (kind == 0 || (!full_seen && cmds_sent > 500)) begin
				// Fill to the brim, try one more, then wrap the pointers round.
				full_seen = 1'b1;
				drain_queue();
				load_mirror(DEPTH, $urandom_range(0, 1));
				send_cmd(OP_ENQ, rand_word());
				send_cmd(OP_CHK, rand_word());
				send_cmd(OP_DEQ, rand_word());
				send_cmd(OP_ENQ, rand_word());
				send_cmd(OP_CHK, rand_word());
			end else if (kind <= 12) begin
				drain_queue();
				n = (kind <= 10) ? $urandom_range(0, 12) : $urandom_range(13, DEPTH);
				load_mirror(n, ($urandom_range(0, 2) == 0));
				if ($urandom_range(0, 1) == 0) begin
					send_cmd($urandom_range(0, 1) ? OP_DEQ : OP_ENQ, rand_word());
					send_cmd(OP_CHK, rand_word());
				end
			end else begin
				repeat (15) begin
					n = $urandom_range(0, 19);
					send_cmd((n < 9) ? OP_ENQ : ((n < 16) ? OP_DEQ : OP_CHK), rand_word());
				end
			end
		end

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		end_of_test <= 1'b1;
		repeat (2) @(posedge clk);
		if (fail_count == 0) begin
			$display("[circular_queue_palindrome_check] OK");
		end else begin
			$display("[circular_queue_palindrome_check] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ circular_queue_palindrome_check.f @@
hw/rtl/cqpc_pkg.sv
hw/rtl/cqpc_chan_if.sv
hw/rtl/cqpc_dp.sv
hw/rtl/cqpc_ctrl.sv
hw/rtl/circular_queue_palindrome_check.sv
tb/sv/cqpc_result_checker.sv
tb/sv/tb_circular_queue_palindrome_check.sv
